[hw/rtl/pqmx_pkg.sv]
package pqmx_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_PULL   = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic        [1:0]  mode;
    logic signed [31:0] value_in;
    logic signed [15:0] priority_in;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic        [1:0]  status;
    logic        [4:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // per-cycle shift control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pull;
  } cell_ctl_t;

endpackage

[hw/rtl/pqmx_cell.sv]
module pqmx_cell
  import pqmx_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  entry_t    new_entry,
  input  entry_t    prev_entry,
  input  logic      prev_ge,
  input  entry_t    next_entry,
  output logic      ge,
  output entry_t    entry
);

  entry_t entry_next;

  // this cell holds something that ranks at or above the new entry
  assign ge = occ && (entry.prio >= new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (!ge) begin
        entry_next = prev_ge ? new_entry : prev_entry;
      end
    end else if (ctl.pull) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[hw/rtl/priority_queue_max_extract.sv]
// Bounded max-priority queue built as a sorted row of cells. For every operation
// (insert, pull, peek) a command beat is accepted whenever start is high, busy
// stays low, and the result beat appears with done high on the cycle right
// after acceptance, for exactly that one cycle. Commands may therefore be
// issued back to back. Each cell of the row picks its next entry from itself,
// its two neighbors and the incoming pair, so the head cell always holds the
// winner (highest priority, earliest arrival among equals). The receiver
// cannot stall; a result must be captured on the cycle it is shown.
module priority_queue_max_extract
  import pqmx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  entry_t    entries [CAPACITY];
  entry_t    new_entry;
  logic      ge_chain [CAPACITY+1];
  cell_ctl_t ctl;

  logic    accept;
  logic    is_full;
  logic    is_empty;
  mode_t   mode;
  rsp_t    rsp_next;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  // busy is tied low, so nothing ever holds commands off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign mode     = mode_t'(cmd.mode);
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  assign new_entry.value = cmd.value_in;
  assign new_entry.prio  = cmd.priority_in;

  // decode the beat into cell row control
  always_comb begin
    ctl = '0;
    if (accept) begin
      ctl.ins  = (mode == MODE_INSERT) && !is_full;
      ctl.pull = (mode == MODE_PULL) && !is_empty;
    end
  end

  // head of the chain: no cell ahead, so the new entry is taken there
  // unless the head itself ranks at or above it
  assign ge_chain[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   occ_i;

    assign occ_i = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_e = new_entry;
    end else begin : g_mid
      assign prev_e = entries[i-1];
    end

    // tail cell pulls in its own content; it leaves the live range anyway
    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = entries[i];
    end else begin : g_body
      assign next_e = entries[i+1];
    end

    pqmx_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ_i),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_ge    (ge_chain[i]),
      .next_entry (next_e),
      .ge         (ge_chain[i+1]),
      .entry      (entries[i])
    );
  end

  // occupancy tracking
  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pull) begin
      count_next = count - CNT_W'(1);
    end
  end

  // occupancy port shows the low bits of the count as it stands after the command
  assign occ_wide = (CNT_W+OCC_W)'(count_next);

  // result beat built from the head cell before it shifts
  always_comb begin
    rsp_next           = '0;
    rsp_next.occupancy = occ_wide[OCC_W-1:0];
    unique case (mode) inside
      MODE_INSERT: begin
        if (is_full) begin
          rsp_next.status = ST_FULL;
        end
      end
      MODE_PULL, MODE_PEEK: begin
        if (is_empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.value_out = entries[0].value;
        end
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // payload register, qualified by done
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // a result beat only follows an accepted command
  a_done_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !rst))
    else $error("result beat without a command");

  // the cell row never holds more than it has cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // a refused insert means the queue really was full and stays so
  a_full_consistent: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (count == CNT_W'(CAPACITY)))
    else $error("full status while queue not full");

  // an empty report leaves the queue empty
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EMPTY) |-> (count == '0))
    else $error("empty status while queue holds entries");

endmodule

[dv/priority_queue_max_extract_test.sv]
module priority_queue_max_extract_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pqmx_pkg::*;

  // ---------------------------------------------------------------------------
  // queue tracker: holds its own copy of the queue contents, predicts the
  // response of every accepted command beat and checks response beats in order
  // ---------------------------------------------------------------------------
  class pq_tracker;
    entry_t held[$];        // entries in arrival order, oldest first
    rsp_t   due_rsp[$];     // predicted responses not yet seen
    int     mismatches = 0;

    function int outstanding();
      return due_rsp.size();
    endfunction

    task log_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // index of the first held entry with the greatest priority
    function int best_index();
      int best = 0;
      for (int i = 1; i < held.size(); i++) begin
        if ($signed(held[i].prio) > $signed(held[best].prio))
          best = i;
      end
      return best;
    endfunction

    task note_cmd(cmd_t c);
      rsp_t   r;
      entry_t e;
      int     b;
      r = '0;
      r.status = ST_OK;
      case (mode_t'(c.mode)) inside
        MODE_INSERT: begin
          if (held.size() >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            e.value = c.value_in;
            e.prio  = c.priority_in;
            held.push_back(e);
          end
        end
        MODE_PULL, MODE_PEEK: begin
          if (held.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            b = best_index();
            r.value_out = held[b].value;
            if (mode_t'(c.mode) == MODE_PULL)
              held.delete(b);
          end
        end
        default: ;  // unused mode: nothing changes
      endcase
      r.occupancy = OCC_W'(held.size());
      due_rsp.push_back(r);
    endtask

    task check_rsp(rsp_t got);
      rsp_t want;
      if (due_rsp.size() == 0) begin
        log_mismatch($sformatf("response beat with nothing expected (value %0d status %0d)",
                               got.value_out, got.status));
      end else begin
        want = due_rsp.pop_front();
        if (got.value_out !== want.value_out)
          log_mismatch($sformatf("value_out %0d, expected %0d", got.value_out, want.value_out));
        if (got.status !== want.status)
          log_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.occupancy !== want.occupancy)
          log_mismatch($sformatf("occupancy %0d, expected %0d",
                                 got.occupancy, want.occupancy));
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block under test
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  priority_queue_max_extract u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  pq_tracker book = new();

  // set while the sender runs without any gaps
  bit quiet = 1'b0;

  // ---------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge, before the block's
  // registers update; the command is noted first so a same-cycle response
  // would still find its expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        book.note_cmd(cmd);
      if (done)
        book.check_rsp(rsp);
    end
  end

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------
  function cmd_t make_cmd(mode_t m, logic signed [31:0] v, logic signed [15:0] p);
    cmd_t c;
    c.mode        = m;
    c.value_in    = v;
    c.priority_in = p;
    return c;
  endfunction

  // present one command beat at a falling edge and hold it until accepted;
  // start stays high between back-to-back beats; each cycle idles at random
  task issue(cmd_t c);
    while (!quiet && $urandom_range(99) < 23) begin
      @(negedge clk);
      start <= 1'b0;
      cmd   <= cmd_t'($bits(cmd_t)'({$urandom(), $urandom()}));  // junk while idle
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  // priority drawn by the current episode's flavor
  function logic signed [15:0] pick_prio(int flavor);
    case (flavor)
      0: return 16'($urandom());
      // narrow band, lots of ties to exercise fifo order within a priority
      1: return 16'(int'($urandom_range(6)) - 3);
      default: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
    endcase
  endfunction

  typedef enum int { EP_FILL, EP_DRAIN, EP_CHURN } episode_t;

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int       counted;
    int       ep_len;
    int       flavor;
    int       r;
    int       spin;
    episode_t ep;
    mode_t    m;

    // synchronous reset, released at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty queue, unused mode, field extremes, ties, drain to empty
    issue(make_cmd(MODE_PULL,   32'sd0,          16'sd0));
    issue(make_cmd(MODE_PEEK,   32'sd0,          16'sd0));
    issue(make_cmd(MODE_NOP,    32'shFFFF_FFFF,  16'shFFFF));
    issue(make_cmd(MODE_INSERT, 32'sh7FFF_FFFF,  16'sh8000));
    issue(make_cmd(MODE_INSERT, 32'sh8000_0000,  16'sh7FFF));
    issue(make_cmd(MODE_INSERT, 32'sh0000_0000,  16'shFFFF));
    issue(make_cmd(MODE_INSERT, 32'shFFFF_FFFF,  16'sh7FFF));  // ties with the second insert
    issue(make_cmd(MODE_INSERT, 32'sh5A5A_A5A5,  16'sh0000));
    issue(make_cmd(MODE_NOP,    32'sh1234_5678,  16'sh0001));
    issue(make_cmd(MODE_PEEK,   32'sd0,          16'sd0));
    issue(make_cmd(MODE_PULL,   32'sd0,          16'sd0));
    issue(make_cmd(MODE_PULL,   32'sd0,          16'sd0));      // later of the tie
    issue(make_cmd(MODE_PEEK,   32'sd0,          16'sd0));
    issue(make_cmd(MODE_PULL,   32'sd0,          16'sd0));
    issue(make_cmd(MODE_PULL,   32'sd0,          16'sd0));
    issue(make_cmd(MODE_PULL,   32'sd0,          16'sd0));
    issue(make_cmd(MODE_PULL,   32'sd0,          16'sd0));      // empty again

    // random episodes; the first one fills so that full is reached early
    counted = 0;
    ep      = EP_FILL;
    while (counted < 1050) begin
      ep_len = $urandom_range(20, 80);
      flavor = $urandom_range(2);
      for (int k = 0; k < ep_len; k++) begin
        // a long stretch with no gaps at all
        quiet = (counted >= 400 && counted < 600);
        r = $urandom_range(99);
        if (r < 2) begin
          m = MODE_NOP;
        end else begin
          r = $urandom_range(99);
          case (ep)
            EP_FILL:  m = (r < 80) ? MODE_INSERT : (r < 90) ? MODE_PULL : MODE_PEEK;
            EP_DRAIN: m = (r < 20) ? MODE_INSERT : (r < 80) ? MODE_PULL : MODE_PEEK;
            default:  m = (r < 46) ? MODE_INSERT : (r < 86) ? MODE_PULL : MODE_PEEK;
          endcase
          counted++;
        end
        // value and priority are random on every beat, used or not
        issue(make_cmd(m, $urandom(), pick_prio(flavor)));
      end
      ep = episode_t'($urandom_range(2));
    end

    @(negedge clk);
    start <= 1'b0;

    // drain the outstanding responses, then wait on a little for strays
    spin = 0;
    while (book.outstanding() > 0 && spin < 200) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    if (book.outstanding() != 0)
      book.log_mismatch($sformatf("%0d responses never arrived", book.outstanding()));

    if (book.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: a correct run needs well under 30 us
  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[priority_queue_max_extract.f]
hw/rtl/pqmx_pkg.sv
hw/rtl/pqmx_cell.sv
hw/rtl/priority_queue_max_extract.sv
dv/priority_queue_max_extract_test.sv
